[src/sgad_pkg.sv]
package sgad_pkg;

    // Arm/disarm modes, as reported on the result channel
    typedef enum logic [1:0] {
        MODE_LOCKED    = 2'd0,
        MODE_UNLOCKING = 2'd1,
        MODE_UNLOCKED  = 2'd2,
        MODE_LOCKING   = 2'd3
    } arm_mode_t;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UNLOCK_HOLD  = 3'd0,
        REG_LOCK_HOLD    = 3'd1,
        REG_AUTO_LOCK    = 3'd2,
        REG_THROTTLE_LOW = 3'd3,
        REG_STICK_LIMIT  = 3'd4
    } cfg_reg_t;

    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 16;
    localparam int THR_W      = 8;
    localparam int STICK_W    = 8;
    localparam int LIMIT_W    = 7;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    // Register reset values
    localparam logic [HOLD_W-1:0]  UNLOCK_HOLD_RST  = 16'd60;
    localparam logic [HOLD_W-1:0]  LOCK_HOLD_RST    = 16'd60;
    localparam logic [HOLD_W-1:0]  AUTO_LOCK_RST    = 16'd200;
    localparam logic [THR_W-1:0]   THROTTLE_LOW_RST = 8'd20;
    localparam logic [LIMIT_W-1:0] STICK_LIMIT_RST  = 7'd25;

endpackage

[src/stick_gesture_arm_disarm_fsm.sv]
// Channel   Direction  Payload
// s_axis    in         tdata = throttle[7:0], yaw_stick[15:8], pitch_stick[23:16],
//                      roll_stick[31:24]
// m_axis    out        tdata = arm_state[1:0], zero[7:2]
// cfg       in         cfg_we / cfg_addr / cfg_wdata, write only
//
// One item per cycle sustained while m_tready holds. An accepted item waits in the
// input register until the result slot frees, then the mode and counter update
// writes the result register. Input and result registers are separate: a stalled
// result still lets one item into an empty input register.
// Reset puts the machine in locked with all counters at zero and the
// registers at their documented values.
module stick_gesture_arm_disarm_fsm
    import sgad_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // throttle, yaw_stick, pitch_stick, roll_stick from the lowest bit up
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // arm_state, then zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;

    // Configuration registers
    logic [HOLD_W-1:0]  unlock_hold_reg;
    logic [HOLD_W-1:0]  lock_hold_reg;
    logic [HOLD_W-1:0]  auto_lock_reg;
    logic [THR_W-1:0]   throttle_low_reg;
    logic [LIMIT_W-1:0] stick_limit_reg;

    // Input stage
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;

    // Machine state
    arm_mode_t              mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] unlock_cnt_reg, unlock_cnt_next;
    logic [COUNT_WIDTH-1:0] lock_cnt_reg, lock_cnt_next;
    logic [COUNT_WIDTH-1:0] auto_cnt_reg, auto_cnt_next;

    // Result stage
    logic      out_valid_reg;
    arm_mode_t out_mode_reg;

    logic advance;

    logic [THR_W-1:0]        throttle;
    logic signed [STICK_W:0] yaw, pitch, roll, lim_pos, lim_neg;
    logic                    thr_low, unlock_gesture, lock_gesture;
    logic [COUNT_WIDTH-1:0]  unlock_inc, lock_inc, auto_inc;
    logic                    unlock_done, lock_done, auto_done;

    // Move the input item into the machine when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_mode_reg);

    // Write configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_hold_reg  <= UNLOCK_HOLD_RST;
            lock_hold_reg    <= LOCK_HOLD_RST;
            auto_lock_reg    <= AUTO_LOCK_RST;
            throttle_low_reg <= THROTTLE_LOW_RST;
            stick_limit_reg  <= STICK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_UNLOCK_HOLD:  unlock_hold_reg  <= cfg_wdata;
                REG_LOCK_HOLD:    lock_hold_reg    <= cfg_wdata;
                REG_AUTO_LOCK:    auto_lock_reg    <= cfg_wdata;
                REG_THROTTLE_LOW: throttle_low_reg <= cfg_wdata[THR_W-1:0];
                REG_STICK_LIMIT:  stick_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Decode the sample: throttle low and the two gestures
    always_comb
    begin
        throttle = in_data_reg[THR_W-1:0];
        yaw      = {in_data_reg[2*STICK_W-1], in_data_reg[2*STICK_W-1:STICK_W]};
        pitch    = {in_data_reg[3*STICK_W-1], in_data_reg[3*STICK_W-1:2*STICK_W]};
        roll     = {in_data_reg[4*STICK_W-1], in_data_reg[4*STICK_W-1:3*STICK_W]};
        lim_pos  = $signed({2'b00, stick_limit_reg});
        lim_neg  = -lim_pos;
        thr_low  = throttle <= throttle_low_reg;
        unlock_gesture = thr_low && (yaw <= lim_neg) && (pitch >= lim_pos)
                         && (roll <= lim_neg);
        lock_gesture   = thr_low && (yaw >= lim_pos) && (pitch >= lim_pos)
                         && (roll >= lim_pos);
    end

    // Counter increments wrap at the counter width
    always_comb
    begin
        unlock_inc  = unlock_cnt_reg + 1'b1;
        lock_inc    = lock_cnt_reg + 1'b1;
        auto_inc    = auto_cnt_reg + 1'b1;
        unlock_done = CMP_W'(unlock_inc) > CMP_W'(unlock_hold_reg);
        lock_done   = CMP_W'(lock_inc) > CMP_W'(lock_hold_reg);
        auto_done   = CMP_W'(auto_inc) > CMP_W'(auto_lock_reg);
    end

    // Next mode and counters
    always_comb
    begin
        mode_next       = mode_reg;
        unlock_cnt_next = unlock_cnt_reg;
        lock_cnt_next   = lock_cnt_reg;
        auto_cnt_next   = auto_cnt_reg;
        unique case (mode_reg) inside
            MODE_LOCKED, MODE_UNLOCKING:
            begin
                if (unlock_gesture)
                begin
                    if (unlock_done)
                    begin
                        unlock_cnt_next = '0;
                        mode_next       = MODE_UNLOCKED;
                    end
                    else
                    begin
                        unlock_cnt_next = unlock_inc;
                        mode_next       = MODE_UNLOCKING;
                    end
                end
                else
                begin
                    unlock_cnt_next = '0;
                    mode_next       = MODE_LOCKED;
                end
            end
            MODE_UNLOCKED, MODE_LOCKING:
            begin
                if (lock_gesture)
                begin
                    if (lock_done)
                    begin
                        lock_cnt_next = '0;
                        mode_next     = MODE_LOCKED;
                    end
                    else
                    begin
                        lock_cnt_next = lock_inc;
                        mode_next     = MODE_LOCKING;
                    end
                end
                else if (thr_low)
                begin
                    // auto-lock path keeps the mode until the count runs out
                    if (auto_done)
                    begin
                        auto_cnt_next = '0;
                        mode_next     = MODE_LOCKED;
                    end
                    else
                    begin
                        auto_cnt_next = auto_inc;
                    end
                end
                else
                begin
                    mode_next     = MODE_UNLOCKED;
                    lock_cnt_next = '0;
                    auto_cnt_next = '0;
                end
            end
        endcase
    end

    // Hold the machine state; advance one item at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LOCKED;
            unlock_cnt_reg <= '0;
            lock_cnt_reg   <= '0;
            auto_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            unlock_cnt_reg <= unlock_cnt_next;
            lock_cnt_reg   <= lock_cnt_next;
            auto_cnt_reg   <= auto_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg <= mode_next;
        end
    end

endmodule

[src/sgad_checker.sv]
module sgad_checker
    import sgad_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    arm_mode_t last_mode_reg;
    logic      out_take;

    assign out_take = m_tvalid && m_tready;

    // Track the last delivered mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mode_reg <= MODE_LOCKED;
        end
        else if (out_take)
        begin
            last_mode_reg <= arm_mode_t'(m_tdata[1:0]);
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Padding above the mode stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:2] == '0)
        else $error("result padding not zero");

    // The disarmed side never jumps straight into locking
    a_no_lock_from_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (last_mode_reg == MODE_LOCKED || last_mode_reg == MODE_UNLOCKING)
        |-> m_tdata[1:0] != MODE_LOCKING)
        else $error("locking reached from a disarmed mode");

    // The armed side never goes to unlocking
    a_no_unlocking_from_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (last_mode_reg == MODE_UNLOCKED || last_mode_reg == MODE_LOCKING)
        |-> m_tdata[1:0] != MODE_UNLOCKING)
        else $error("unlocking reached from an armed mode");

    // Input ready is never withheld with an empty result slot and no stall
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !s_tready |=> m_tvalid)
        else $error("input stalled with result path free");

endmodule

bind stick_gesture_arm_disarm_fsm sgad_checker u_sgad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
